// File: sv/tmhq_pkg.sv
// Package for the timer min-heap queue: types, widths and controller states.
// No dependencies; used by every file of the block.
`default_nettype none

package tmhq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int CNT_W        = 6;
    localparam int TIME_W       = 48;
    localparam int SIG_W        = 32;
    localparam int DLY_W        = 32;

    typedef enum logic
    {
        OP_SCHEDULE = 1'b0,
        OP_TICK     = 1'b1
    } op_t;

    typedef enum logic
    {
        KIND_FIRED   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed
    {
        op_t                      op;
        logic [SIG_W-1:0]         signal_id;
        logic signed [DLY_W-1:0]  delay_ms;
        logic [TIME_W-1:0]        now_ms;
    } req_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [SIG_W-1:0]   fired_signal;
        logic               last;
        logic [CNT_W-1:0]   pending_count;
        logic [TIME_W-1:0]  wait_ms;
        logic               none_pending;
        logic               overflow;
    } rsp_t;

    typedef struct packed
    {
        logic [TIME_W-1:0]  due;
        logic [SIG_W-1:0]   signal;
    } entry_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_FIRE_NOW,
        S_SUM_RD,
        S_SUM_OUT,
        S_INS_CHK,
        S_INS_CMP,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_FIRE,
        S_DEL_LAST,
        S_DEL_L,
        S_DEL_R,
        S_DEL_CMP,
        S_DEL_MOVE
    } state_t;

endpackage

`default_nettype wire

// File: sv/timer_min_heap_queue_top.sv
// Top level of the timer min-heap queue: heap memory and its sequencer.
// Depends on tmhq_pkg.
//
// Usage: requests enter on req (valid/stall); results leave on rsp (valid/stall).
// A schedule request with a positive delay inserts an entry due at the stored time
// plus the delay (overflow if full); a zero or negative delay fires its signal at once.
// A tick request stores the new time and fires every entry due at or before it.
// Each request ends with one summary result (kind set, last set).
// One request is worked on at a time; req_stall is high until its summary
// has been loaded into the output register.
// The sequencer climbs the heap for an insert and sifts down after each fired entry
// of a tick; the heap memory has one read and one write port, with a registered read.
// Reset empties the heap and clears the stored time to zero.
// When the receiver stalls, the held result stays and the sequencer waits before its next result.
`default_nettype none

module timer_min_heap_queue_top #(
    parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire tmhq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output tmhq_pkg::rsp_t     rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = tmhq_pkg::CNT_W;
    localparam int NW = CW + 1;
    localparam int TW = tmhq_pkg::TIME_W;

    tmhq_pkg::entry_t heap_mem [CAPACITY];
    tmhq_pkg::entry_t rd_entry_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    tmhq_pkg::entry_t wr_data;

    tmhq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TW-1:0]    now_reg, now_next;
    tmhq_pkg::entry_t new_reg, new_next;
    tmhq_pkg::entry_t best_reg, best_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    par_reg, par_next;
    logic [NW-1:0]    best_idx_reg, best_idx_next;
    logic             best_child_reg, best_child_next;
    logic             ovf_reg, ovf_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tmhq_pkg::rsp_t   rsp_reg;

    logic             emit;
    tmhq_pkg::rsp_t   emit_data;
    logic             out_free;
    logic [TW:0]      due_sum;
    logic             positive;
    logic [NW-1:0]    left_idx;
    logic [NW-1:0]    right_idx;
    logic [NW-1:0]    count_ext;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= heap_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmhq_pkg::S_IDLE;
            count_reg      <= '0;
            now_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            best_child_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            rsp_valid_reg  <= rsp_valid_next;
            ovf_reg        <= ovf_next;
            best_child_reg <= best_child_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg      <= new_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
        par_reg      <= par_next;
        best_idx_reg <= best_idx_next;
        if (emit)
        begin
            rsp_reg <= emit_data;
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign due_sum   = {1'b0, now_reg} + {{(TW + 1 - tmhq_pkg::DLY_W){1'b0}}, req.delay_ms};
    assign positive  = (req.delay_ms != '0) && !req.delay_ms[tmhq_pkg::DLY_W-1];
    assign left_idx  = NW'({cur_reg, 1'b1});
    assign right_idx = left_idx + NW'(1);
    assign count_ext = {1'b0, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        now_next        = now_reg;
        new_next        = new_reg;
        best_next       = best_reg;
        cur_next        = cur_reg;
        par_next        = par_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        ovf_next        = ovf_reg;
        req_stall       = 1'b1;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_reg;
        emit            = 1'b0;
        emit_data       = '0;

        unique case (state_reg)
            tmhq_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ovf_next        = 1'b0;
                    new_next.signal = req.signal_id;
                    if (req.op == tmhq_pkg::OP_TICK)
                    begin
                        now_next   = req.now_ms;
                        state_next = tmhq_pkg::S_TICK_RD;
                    end
                    else if (!positive)
                    begin
                        state_next = tmhq_pkg::S_FIRE_NOW;
                    end
                    else if (count_ext >= NW'(CAPACITY))
                    begin
                        ovf_next   = 1'b1;
                        state_next = tmhq_pkg::S_SUM_RD;
                    end
                    else
                    begin
                        new_next.due = due_sum[TW] ? {TW{1'b1}} : due_sum[TW-1:0];
                        cur_next     = count_ext;
                        count_next   = count_reg + CW'(1);
                        state_next   = tmhq_pkg::S_INS_CHK;
                    end
                end
            end
            tmhq_pkg::S_FIRE_NOW:
            begin
                if (out_free)
                begin
                    emit                   = 1'b1;
                    emit_data.kind         = tmhq_pkg::KIND_FIRED;
                    emit_data.fired_signal = new_reg.signal;
                    state_next             = tmhq_pkg::S_SUM_RD;
                end
            end
            tmhq_pkg::S_SUM_RD:
            begin
                rd_en      = 1'b1;
                state_next = tmhq_pkg::S_SUM_OUT;
            end
            tmhq_pkg::S_SUM_OUT:
            begin
                if (out_free)
                begin
                    emit                    = 1'b1;
                    emit_data.kind          = tmhq_pkg::KIND_SUMMARY;
                    emit_data.last          = 1'b1;
                    emit_data.pending_count = count_reg;
                    emit_data.overflow      = ovf_reg;
                    emit_data.none_pending  = (count_reg == '0);
                    if (count_reg != '0 && rd_entry_reg.due >= now_reg)
                    begin
                        emit_data.wait_ms = rd_entry_reg.due - now_reg;
                    end
                    state_next = tmhq_pkg::S_IDLE;
                end
            end
            tmhq_pkg::S_INS_CHK:
            begin
                if (cur_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = tmhq_pkg::S_SUM_RD;
                end
                else
                begin
                    par_next   = (cur_reg - NW'(1)) >> 1;
                    rd_en      = 1'b1;
                    rd_addr    = IW'((cur_reg - NW'(1)) >> 1);
                    state_next = tmhq_pkg::S_INS_CMP;
                end
            end
            tmhq_pkg::S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg[IW-1:0];
                if (rd_entry_reg.due > new_reg.due)
                begin
                    wr_data    = rd_entry_reg;
                    cur_next   = par_reg;
                    state_next = tmhq_pkg::S_INS_CHK;
                end
                else
                begin
                    state_next = tmhq_pkg::S_SUM_RD;
                end
            end
            tmhq_pkg::S_TICK_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = tmhq_pkg::S_SUM_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = tmhq_pkg::S_TICK_CHK;
                end
            end
            tmhq_pkg::S_TICK_CHK:
            begin
                if (rd_entry_reg.due <= now_reg)
                begin
                    state_next = tmhq_pkg::S_TICK_FIRE;
                end
                else
                begin
                    state_next = tmhq_pkg::S_SUM_OUT;
                end
            end
            tmhq_pkg::S_TICK_FIRE:
            begin
                if (out_free)
                begin
                    emit                   = 1'b1;
                    emit_data.kind         = tmhq_pkg::KIND_FIRED;
                    emit_data.fired_signal = rd_entry_reg.signal;
                    count_next             = count_reg - CW'(1);
                    rd_en                  = 1'b1;
                    rd_addr                = IW'(count_reg - CW'(1));
                    state_next             = tmhq_pkg::S_DEL_LAST;
                end
            end
            tmhq_pkg::S_DEL_LAST:
            begin
                new_next   = rd_entry_reg;
                cur_next   = '0;
                state_next = tmhq_pkg::S_DEL_L;
            end
            tmhq_pkg::S_DEL_L:
            begin
                if (left_idx < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_idx[IW-1:0];
                    state_next = tmhq_pkg::S_DEL_R;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_reg[IW-1:0];
                    state_next = tmhq_pkg::S_TICK_RD;
                end
            end
            tmhq_pkg::S_DEL_R:
            begin
                if (rd_entry_reg.due < new_reg.due)
                begin
                    best_next       = rd_entry_reg;
                    best_idx_next   = left_idx;
                    best_child_next = 1'b1;
                end
                else
                begin
                    best_next       = new_reg;
                    best_child_next = 1'b0;
                end
                if (right_idx < count_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = right_idx[IW-1:0];
                    state_next = tmhq_pkg::S_DEL_CMP;
                end
                else
                begin
                    state_next = tmhq_pkg::S_DEL_MOVE;
                end
            end
            tmhq_pkg::S_DEL_CMP:
            begin
                if (rd_entry_reg.due < best_reg.due)
                begin
                    best_next       = rd_entry_reg;
                    best_idx_next   = right_idx;
                    best_child_next = 1'b1;
                end
                state_next = tmhq_pkg::S_DEL_MOVE;
            end
            tmhq_pkg::S_DEL_MOVE:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg[IW-1:0];
                if (best_child_reg)
                begin
                    wr_data    = best_reg;
                    cur_next   = best_idx_reg;
                    state_next = tmhq_pkg::S_DEL_L;
                end
                else
                begin
                    state_next = tmhq_pkg::S_TICK_RD;
                end
            end
            default:
            begin
                state_next = tmhq_pkg::S_IDLE;
            end
        endcase

        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: sv/tmhq_checker.sv
// Port-level checker for the timer min-heap queue, bound to the top level.
// Depends on tmhq_pkg and timer_min_heap_queue_top.
`default_nettype none

module tmhq_checker #(
    parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire tmhq_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_stall,
    input wire tmhq_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled result changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("Request taken while another is in progress.");

    a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == tmhq_pkg::KIND_SUMMARY |->
            rsp.last && rsp.pending_count <= tmhq_pkg::CNT_W'(CAPACITY))
        else $error("Malformed summary result.");

    a_fired_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == tmhq_pkg::KIND_FIRED |-> !rsp.last && !rsp.overflow)
        else $error("Malformed fired result.");

    a_empty_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.none_pending |-> rsp.wait_ms == '0 && rsp.pending_count == '0)
        else $error("Empty summary with a wait or a count.");

endmodule

bind timer_min_heap_queue_top tmhq_checker #(.CAPACITY(CAPACITY)) u_tmhq_checker (.*);

`default_nettype wire
